FILE: src/tdpl_pkg.sv
// Shared types, constants and codes for the touch duration pattern lock.
// No dependencies; every other file of the block imports this package.
package tdpl_pkg;

  localparam int PAT_LEN    = 9;
  localparam int CNT_W      = $clog2(PAT_LEN + 1);
  localparam int LVL_W      = 16;
  localparam int MS_W       = 16;
  localparam int TS_W       = 32;
  localparam int FIFO_DEPTH = 2;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 24;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_ENTRY_BASE    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_VALIDATE_BASE = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_LONG_PRESS    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_GAP_LIMIT     = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_VALIDATE_LIM  = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_PATTERN       = 3'd5;

  localparam logic [MS_W-1:0]    LONG_PRESS_RST   = 16'd3000;
  localparam logic [MS_W-1:0]    GAP_LIMIT_RST    = 16'd10000;
  localparam logic [MS_W-1:0]    VALIDATE_LIM_RST = 16'd15000;
  localparam logic [PAT_LEN-1:0] PATTERN_RST      = 9'd455;

  // verdict codes
  localparam logic [2:0] VERD_NONE         = 3'd0;
  localparam logic [2:0] VERD_APPROVED     = 3'd1;
  localparam logic [2:0] VERD_REJECTED     = 3'd2;
  localparam logic [2:0] VERD_GAP_TIMEOUT  = 3'd3;
  localparam logic [2:0] VERD_VAL_TIMEOUT  = 3'd4;
  localparam logic [2:0] VERD_WRONG_PAD    = 3'd5;

  typedef struct packed {
    logic            entry_touch;
    logic            validate_touch;
    logic [TS_W-1:0] now_ms;
  } sample_t;

  typedef struct packed {
    logic [PAT_LEN-1:0] mismatch_mask;
    logic [2:0]         verdict;
    logic [CNT_W-1:0]   touches_held;
    logic               touch_was_long;
    logic               touch_recorded;
  } result_t;

  typedef struct packed {
    logic [MS_W-1:0]    long_press_ms;
    logic [MS_W-1:0]    gap_limit_ms;
    logic [MS_W-1:0]    validate_limit_ms;
    logic [PAT_LEN-1:0] expected_pattern;
  } back_cfg_t;

endpackage

FILE: src/tdpl_front.sv
// Front end: turns a raw pad beat into touch flags plus timestamp.
// Depends on tdpl_pkg.
module tdpl_front import tdpl_pkg::*; (
  input  logic [LVL_W-1:0] entry_level,
  input  logic [LVL_W-1:0] validate_level,
  input  logic [TS_W-1:0]  now_ms,
  input  logic [LVL_W-1:0] entry_baseline,
  input  logic [LVL_W-1:0] validate_baseline,
  output sample_t          sample
);

  always_comb begin
    sample.entry_touch    = {entry_level, 1'b0} < {1'b0, entry_baseline};
    sample.validate_touch = {validate_level, 1'b0} < {1'b0, validate_baseline};
    sample.now_ms         = now_ms;
  end

endmodule

FILE: src/tdpl_fifo.sv
// Short queue of classified samples between front and back end.
// Depends on tdpl_pkg.
module tdpl_fifo import tdpl_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  sample_t push_data,
  output logic    full,
  input  logic    pop,
  output logic    not_empty,
  output sample_t pop_data
);

  localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  sample_t       mem_r [FIFO_DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full      = (count_r == CW'(FIFO_DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: src/tdpl_back.sv
// Back end: press timing, class store, verdicts and the output register.
// Depends on tdpl_pkg; fed by tdpl_fifo.
module tdpl_back import tdpl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  back_cfg_t cfg,
  input  logic      q_valid,
  input  sample_t   q_data,
  output logic      q_pop,
  output logic      res_valid,
  output result_t   res,
  input  logic      res_ready
);

  logic               pressed_r, pressed_nxt;
  logic [TS_W-1:0]    press_start_r, press_start_nxt;
  logic [TS_W-1:0]    last_touch_r, last_touch_nxt;
  logic [CNT_W-1:0]   held_r, held_nxt;
  logic               await_r, await_nxt;
  logic [PAT_LEN-1:0] classes_r, classes_nxt;
  logic               out_valid_r;
  result_t            out_r, out_nxt;

  logic [TS_W-1:0]    duration;
  logic [TS_W-1:0]    elapsed;
  logic               is_long;

  assign q_pop     = q_valid && (!out_valid_r || res_ready);
  assign res_valid = out_valid_r;
  assign res       = out_r;

  always_comb begin
    pressed_nxt     = pressed_r;
    press_start_nxt = press_start_r;
    last_touch_nxt  = last_touch_r;
    held_nxt        = held_r;
    await_nxt       = await_r;
    classes_nxt     = classes_r;
    out_nxt         = '0;

    duration = q_data.now_ms - press_start_r;
    is_long  = duration >= {{(TS_W-MS_W){1'b0}}, cfg.long_press_ms};

    if (q_data.entry_touch) begin
      if (!pressed_r) begin
        pressed_nxt     = 1'b1;
        press_start_nxt = q_data.now_ms;
      end
    end else if (pressed_r) begin
      pressed_nxt = 1'b0;
      if (!await_r && held_r < CNT_W'(PAT_LEN)) begin
        for (int i = 0; i < PAT_LEN; i++) begin
          if (held_r == CNT_W'(i)) begin
            classes_nxt[i] = is_long;
          end
        end
        held_nxt               = held_r + 1'b1;
        last_touch_nxt         = q_data.now_ms;
        out_nxt.touch_recorded = 1'b1;
        out_nxt.touch_was_long = is_long;
        if (held_nxt == CNT_W'(PAT_LEN)) begin
          await_nxt = 1'b1;
        end
      end
    end

    elapsed = q_data.now_ms - last_touch_nxt;

    if (await_nxt) begin
      if (q_data.entry_touch) begin
        out_nxt.verdict = VERD_WRONG_PAD;
      end else if (q_data.validate_touch) begin
        out_nxt.mismatch_mask = classes_nxt ^ cfg.expected_pattern;
        out_nxt.verdict = (out_nxt.mismatch_mask != '0) ? VERD_REJECTED : VERD_APPROVED;
        held_nxt       = '0;
        await_nxt      = 1'b0;
        last_touch_nxt = '0;
      end else if (elapsed > {{(TS_W-MS_W){1'b0}}, cfg.validate_limit_ms}) begin
        out_nxt.verdict = VERD_VAL_TIMEOUT;
        held_nxt       = '0;
        await_nxt      = 1'b0;
        last_touch_nxt = '0;
      end
    end else if (held_nxt != '0 &&
                 elapsed > {{(TS_W-MS_W){1'b0}}, cfg.gap_limit_ms}) begin
      out_nxt.verdict = VERD_GAP_TIMEOUT;
      held_nxt       = '0;
      last_touch_nxt = '0;
    end

    out_nxt.touches_held = held_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pressed_r     <= 1'b0;
      press_start_r <= '0;
      last_touch_r  <= '0;
      held_r        <= '0;
      await_r       <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (q_pop) begin
        pressed_r     <= pressed_nxt;
        press_start_r <= press_start_nxt;
        last_touch_r  <= last_touch_nxt;
        held_r        <= held_nxt;
        await_r       <= await_nxt;
        out_valid_r   <= 1'b1;
      end else if (res_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      classes_r <= classes_nxt;
      out_r     <= out_nxt;
    end
  end

  a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= CNT_W'(PAT_LEN))
    else $error("held count beyond pattern length");

  a_await_full: assert property (@(posedge clk) disable iff (!rst_n)
    await_r |-> held_r == CNT_W'(PAT_LEN))
    else $error("awaiting validation without a full pattern");

  a_mask_only_on_check: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.verdict != VERD_APPROVED && out_r.verdict != VERD_REJECTED)
      |-> out_r.mismatch_mask == '0)
    else $error("mismatch mask set without a pattern check");

  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.verdict == VERD_APPROVED || out_r.verdict == VERD_REJECTED ||
                     out_r.verdict == VERD_GAP_TIMEOUT || out_r.verdict == VERD_VAL_TIMEOUT))
      |-> out_r.touches_held == '0)
    else $error("restart verdict with touches still held");

endmodule

FILE: src/touch_duration_pattern_lock_unit.sv
// Top level of the touch duration pattern lock: config registers and stream ports.
// Depends on tdpl_pkg, tdpl_front, tdpl_fifo and tdpl_back.
//
// Takes one pad sample beat per clock while input ready is high and returns
// exactly one result beat per sample, in order. Each beat is held in the
// queue and then in the output register: the front end classifies both pads
// and pushes into a two-entry queue, and while the output is not stalled the
// back end retires one queued sample per cycle into the output register, and
// the throughput is one sample per cycle; input ready drops only when the
// queue is full because the output is stalled. Write configuration only while
// no sample is in flight.
module touch_duration_pattern_lock_unit import tdpl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [15:0] entry_level, [31:16] validate_level, [63:32] now_ms
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [0] touch_recorded, [1] touch_was_long, [5:2] touches_held,
  // [8:6] verdict, [17:9] mismatch_mask, [23:18] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [LVL_W-1:0]   entry_base_r;
  logic [LVL_W-1:0]   validate_base_r;
  logic [MS_W-1:0]    long_press_r;
  logic [MS_W-1:0]    gap_limit_r;
  logic [MS_W-1:0]    validate_lim_r;
  logic [PAT_LEN-1:0] pattern_r;

  back_cfg_t back_cfg;
  sample_t   sample;
  sample_t   q_data;
  logic      q_full;
  logic      q_valid;
  logic      q_pop;
  result_t   res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_base_r    <= '0;
      validate_base_r <= '0;
      long_press_r    <= LONG_PRESS_RST;
      gap_limit_r     <= GAP_LIMIT_RST;
      validate_lim_r  <= VALIDATE_LIM_RST;
      pattern_r       <= PATTERN_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_ENTRY_BASE:    entry_base_r    <= cfg_wdata[LVL_W-1:0];
        REG_VALIDATE_BASE: validate_base_r <= cfg_wdata[LVL_W-1:0];
        REG_LONG_PRESS:    long_press_r    <= cfg_wdata[MS_W-1:0];
        REG_GAP_LIMIT:     gap_limit_r     <= cfg_wdata[MS_W-1:0];
        REG_VALIDATE_LIM:  validate_lim_r  <= cfg_wdata[MS_W-1:0];
        REG_PATTERN:       pattern_r       <= cfg_wdata[PAT_LEN-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    back_cfg.long_press_ms     = long_press_r;
    back_cfg.gap_limit_ms      = gap_limit_r;
    back_cfg.validate_limit_ms = validate_lim_r;
    back_cfg.expected_pattern  = pattern_r;
  end

  assign in_tready = !q_full;

  tdpl_front u_front (
    .entry_level       (in_tdata[15:0]),
    .validate_level    (in_tdata[31:16]),
    .now_ms            (in_tdata[63:32]),
    .entry_baseline    (entry_base_r),
    .validate_baseline (validate_base_r),
    .sample            (sample)
  );

  tdpl_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_tvalid && !q_full),
    .push_data (sample),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_data)
  );

  tdpl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (back_cfg),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .res_valid (out_tvalid),
    .res       (res),
    .res_ready (out_tready)
  );

  assign out_tdata = {{(OUT_DATA_W - $bits(result_t)){1'b0}}, res};

endmodule

FILE: verif/tb_touch_duration_pattern_lock_unit.sv
// Testbench for touch_duration_pattern_lock_unit: a directed table, then random phases.
// Depends on tdpl_pkg and the RTL. Results are checked against the lock model or literal rows.
module tb_touch_duration_pattern_lock_unit;
  import tdpl_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DIR_ROWS       = 25;
  localparam int RAND_PHASES    = 8;

  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_HI = 3'd7;

  localparam logic [LVL_W-1:0] LVL_TOUCH = 16'd0;
  localparam logic [LVL_W-1:0] LVL_FREE  = 16'hFFFF;
  localparam logic [TS_W-1:0]  T_START   = 32'hFFFF_F000;

  localparam result_t RES_QUIET     = '0;
  localparam result_t RES_WRONG_PAD = '{9'd0, VERD_WRONG_PAD, 4'd9, 1'b0, 1'b0};
  localparam result_t RES_APPROVED  = '{9'd0, VERD_APPROVED, 4'd0, 1'b0, 1'b0};
  localparam result_t RES_GAP       = '{9'd0, VERD_GAP_TIMEOUT, 4'd0, 1'b0, 1'b0};

  typedef struct packed {
    logic [LVL_W-1:0] entry_level;
    logic [LVL_W-1:0] validate_level;
    logic [TS_W-1:0]  dt;
    logic             lit;
    result_t          res;
  } dir_row_t;

  // baselines are 1000 here; the other registers keep their reset values
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{LVL_FREE,  LVL_FREE,  32'd0,     1'b1, RES_QUIET},      // idle after reset
    '{LVL_TOUCH, LVL_FREE,  32'd100,   1'b0, RES_QUIET},      // touch 0, long at the limit
    '{LVL_FREE,  LVL_FREE,  32'd3000,  1'b0, RES_QUIET},
    '{16'd499,   LVL_FREE,  32'd100,   1'b0, RES_QUIET},      // touch 1, levels on the boundary
    '{16'd500,   LVL_FREE,  32'd3000,  1'b0, RES_QUIET},      // timestamp wraps during this press
    '{LVL_TOUCH, LVL_FREE,  32'd100,   1'b0, RES_QUIET},
    '{LVL_FREE,  LVL_FREE,  32'd3000,  1'b0, RES_QUIET},
    '{LVL_TOUCH, LVL_FREE,  32'd100,   1'b0, RES_QUIET},      // touches 3..5 short by one ms
    '{LVL_FREE,  LVL_FREE,  32'd2999,  1'b0, RES_QUIET},
    '{LVL_TOUCH, LVL_FREE,  32'd100,   1'b0, RES_QUIET},
    '{LVL_FREE,  LVL_FREE,  32'd2999,  1'b0, RES_QUIET},
    '{LVL_TOUCH, LVL_FREE,  32'd100,   1'b0, RES_QUIET},
    '{LVL_FREE,  LVL_FREE,  32'd2999,  1'b0, RES_QUIET},
    '{LVL_TOUCH, LVL_FREE,  32'd100,   1'b0, RES_QUIET},
    '{LVL_FREE,  LVL_FREE,  32'd3000,  1'b0, RES_QUIET},
    '{LVL_TOUCH, LVL_FREE,  32'd100,   1'b0, RES_QUIET},
    '{LVL_FREE,  LVL_FREE,  32'd3000,  1'b0, RES_QUIET},
    '{LVL_TOUCH, LVL_FREE,  32'd100,   1'b0, RES_QUIET},
    '{LVL_FREE,  LVL_FREE,  32'd3000,  1'b0, RES_QUIET},      // ninth touch, now awaiting
    '{LVL_TOUCH, LVL_TOUCH, 32'd100,   1'b1, RES_WRONG_PAD},  // entry pad wins over validate
    '{LVL_FREE,  LVL_FREE,  32'd100,   1'b0, RES_QUIET},      // release while awaiting, not stored
    '{LVL_FREE,  LVL_TOUCH, 32'd100,   1'b1, RES_APPROVED},
    '{LVL_TOUCH, LVL_FREE,  32'd100,   1'b0, RES_QUIET},
    '{LVL_FREE,  LVL_FREE,  32'd50,    1'b0, RES_QUIET},
    '{LVL_FREE,  LVL_FREE,  32'd10001, 1'b1, RES_GAP}         // one past the gap limit
  };

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // model copy of the registers
  logic [LVL_W-1:0]   cf_entry_base;
  logic [LVL_W-1:0]   cf_validate_base;
  logic [MS_W-1:0]    cf_long_press;
  logic [MS_W-1:0]    cf_gap_limit;
  logic [MS_W-1:0]    cf_val_limit;
  logic [PAT_LEN-1:0] cf_pattern;

  // model copy of the lock state
  logic               lk_pressed;
  logic [TS_W-1:0]    lk_press_start;
  logic [TS_W-1:0]    lk_last_touch;
  logic [CNT_W-1:0]   lk_held;
  logic               lk_awaiting;
  logic [PAT_LEN-1:0] lk_classes;

  result_t         pending_lock_results [$];
  int              err_count;
  bit              idle_on;
  bit              stall_on;
  logic [TS_W-1:0] gen_t;

  touch_duration_pattern_lock_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void restart_lock();
    lk_held       = '0;
    lk_awaiting   = 1'b0;
    lk_last_touch = '0;
  endfunction

  function automatic result_t predict_lock_result(logic [LVL_W-1:0] e_lvl,
                                                  logic [LVL_W-1:0] v_lvl,
                                                  logic [TS_W-1:0] now);
    result_t            r;
    logic               e_touch;
    logic               v_touch;
    logic               is_long;
    logic [TS_W-1:0]    held_for;
    logic [TS_W-1:0]    since_touch;
    logic [PAT_LEN-1:0] diff;
    r       = '0;
    e_touch = {e_lvl, 1'b0} < {1'b0, cf_entry_base};
    v_touch = {v_lvl, 1'b0} < {1'b0, cf_validate_base};
    if (e_touch) begin
      if (!lk_pressed) begin
        lk_pressed     = 1'b1;
        lk_press_start = now;
      end
    end else if (lk_pressed) begin
      held_for   = now - lk_press_start;
      lk_pressed = 1'b0;
      if (!lk_awaiting && lk_held < PAT_LEN) begin
        is_long             = held_for >= TS_W'(cf_long_press);
        lk_classes[lk_held] = is_long;
        lk_held             = lk_held + 1'b1;
        lk_last_touch       = now;
        r.touch_recorded    = 1'b1;
        r.touch_was_long    = is_long;
        if (lk_held >= PAT_LEN) lk_awaiting = 1'b1;
      end
    end
    since_touch = now - lk_last_touch;
    if (lk_awaiting) begin
      if (e_touch) begin
        r.verdict = VERD_WRONG_PAD;
      end else if (v_touch) begin
        diff            = lk_classes ^ cf_pattern;
        r.mismatch_mask = diff;
        r.verdict       = (diff != '0) ? VERD_REJECTED : VERD_APPROVED;
        restart_lock();
      end else if (since_touch > TS_W'(cf_val_limit)) begin
        r.verdict = VERD_VAL_TIMEOUT;
        restart_lock();
      end
    end else if (lk_held > 0 && since_touch > TS_W'(cf_gap_limit)) begin
      r.verdict = VERD_GAP_TIMEOUT;
      restart_lock();
    end
    r.touches_held = lk_held;
    return r;
  endfunction

  function automatic logic [LVL_W-1:0] pad_level(logic [LVL_W-1:0] base, logic touch);
    int unsigned b;
    b = base;
    if (touch && b > 0) return LVL_W'($urandom_range(0, (b - 1) / 2));
    return LVL_W'($urandom_range((b + 1) / 2, 65535));
  endfunction

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_ENTRY_BASE:    cf_entry_base    = val;
      REG_VALIDATE_BASE: cf_validate_base = val;
      REG_LONG_PRESS:    cf_long_press    = val;
      REG_GAP_LIMIT:     cf_gap_limit     = val;
      REG_VALIDATE_LIM:  cf_val_limit     = val;
      REG_PATTERN:       cf_pattern       = val[PAT_LEN-1:0];
      default: ;
    endcase
  endtask

  task automatic load_lock_config(logic [CFG_DATA_W-1:0] eb, logic [CFG_DATA_W-1:0] vb,
                                  logic [CFG_DATA_W-1:0] lp, logic [CFG_DATA_W-1:0] gl,
                                  logic [CFG_DATA_W-1:0] vl, logic [CFG_DATA_W-1:0] pat);
    write_reg(REG_SPARE_LO, CFG_DATA_W'($urandom_range(0, 65535)));
    write_reg(REG_SPARE_HI, CFG_DATA_W'($urandom_range(0, 65535)));
    write_reg(REG_ENTRY_BASE, eb);
    write_reg(REG_VALIDATE_BASE, vb);
    write_reg(REG_LONG_PRESS, lp);
    write_reg(REG_GAP_LIMIT, gl);
    write_reg(REG_VALIDATE_LIM, vl);
    write_reg(REG_PATTERN, pat);
    cfg_we <= 1'b0;
  endtask

  task automatic settle_lock();
    in_tvalid <= 1'b0;
    while (pending_lock_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_sample(logic [LVL_W-1:0] e_lvl, logic [LVL_W-1:0] v_lvl,
                             logic [TS_W-1:0] now, logic lit, result_t lit_res);
    result_t pred;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {now, v_lvl, e_lvl};
    do @(posedge clk); while (!in_tready);
    pred = predict_lock_result(e_lvl, v_lvl, now);
    pending_lock_results.push_back(lit ? lit_res : pred);
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_lock_results.size() == 0) begin
        $error("result beat with nothing expected: %h", out_tdata);
        err_count++;
      end else begin
        want = pending_lock_results.pop_front();
        got  = out_tdata[$bits(result_t)-1:0];
        check_field("touch_recorded", want.touch_recorded, got.touch_recorded);
        check_field("touch_was_long", want.touch_was_long, got.touch_was_long);
        check_field("touches_held", want.touches_held, got.touches_held);
        check_field("verdict", want.verdict, got.verdict);
        check_field("mismatch_mask", want.mismatch_mask, got.mismatch_mask);
        check_field("pad", 0, out_tdata[OUT_DATA_W-1:$bits(result_t)]);
      end
    end
  end

  initial begin
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (stall_on && $urandom_range(0, 2) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("** touch_duration_pattern_lock_unit: FAILED **");
    $finish;
  end

  initial begin
    logic [LVL_W-1:0] e_lvl;
    logic [LVL_W-1:0] v_lvl;
    logic             e_touch;
    logic             v_touch;
    logic [TS_W-1:0]  want_dur;
    int               roll;
    int               n_items;
    rst_n            <= 1'b0;
    in_tvalid        <= 1'b0;
    in_tdata         <= '0;
    cfg_we           <= 1'b0;
    cfg_addr         <= '0;
    cfg_wdata        <= '0;
    err_count        = 0;
    idle_on          = 1'b1;
    stall_on         = 1'b1;
    cf_entry_base    = '0;
    cf_validate_base = '0;
    cf_long_press    = LONG_PRESS_RST;
    cf_gap_limit     = GAP_LIMIT_RST;
    cf_val_limit     = VALIDATE_LIM_RST;
    cf_pattern       = PATTERN_RST;
    lk_pressed       = 1'b0;
    lk_press_start   = '0;
    lk_last_touch    = '0;
    lk_held          = '0;
    lk_awaiting      = 1'b0;
    lk_classes       = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_reg(REG_ENTRY_BASE, 16'd1000);
    write_reg(REG_VALIDATE_BASE, 16'd1000);
    cfg_we <= 1'b0;
    gen_t = T_START;
    for (int i = 0; i < DIR_ROWS; i++) begin
      gen_t += dir_rows[i].dt;
      send_sample(dir_rows[i].entry_level, dir_rows[i].validate_level, gen_t,
                  dir_rows[i].lit, dir_rows[i].res);
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      settle_lock();
      if (ph == RAND_PHASES - 1) begin
        idle_on  = 1'b0;
        stall_on = 1'b0;
      end
      n_items = 60;
      case (ph)
        0: load_lock_config(16'd40000, 16'd40000, 16'd3000, 16'd10000, 16'd15000,
                            CFG_DATA_W'($urandom_range(0, 65535)));
        1: load_lock_config(16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0);
        2: load_lock_config(16'd1, 16'd1, 16'hFFFF, 16'd0, 16'd0, 16'h01FF);
        3: begin
          // zero baselines: no pad ever reads as touched
          n_items = 20;
          load_lock_config(16'd0, 16'd0, CFG_DATA_W'($urandom_range(0, 5000)),
                           CFG_DATA_W'($urandom_range(0, 20000)),
                           CFG_DATA_W'($urandom_range(0, 20000)),
                           CFG_DATA_W'($urandom_range(0, 65535)));
        end
        default: load_lock_config(CFG_DATA_W'($urandom_range(2000, 65535)),
                                  CFG_DATA_W'($urandom_range(2000, 65535)),
                                  CFG_DATA_W'($urandom_range(1, 3000)),
                                  CFG_DATA_W'($urandom_range(8000, 20000)),
                                  CFG_DATA_W'($urandom_range(8000, 20000)),
                                  CFG_DATA_W'($urandom_range(0, 65535)));
      endcase

      for (int n = 0; n < n_items; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 6) begin
          e_lvl = LVL_W'($urandom_range(0, 65535));
          v_lvl = LVL_W'($urandom_range(0, 65535));
          if ($urandom_range(0, 3) == 0) gen_t = $urandom();
          else gen_t += $urandom_range(0, 400);
        end else begin
          if (lk_pressed) e_touch = $urandom_range(0, 99) < 45;
          else e_touch = $urandom_range(0, 99) < (lk_awaiting ? 12 : 50);
          v_touch = $urandom_range(0, 99) < (lk_held >= PAT_LEN - 1 ? 30 : 4);
          if (lk_pressed && !e_touch) begin
            if ($urandom_range(0, 1) == 1)
              want_dur = TS_W'(cf_long_press) + $urandom_range(0, 2) - 1;
            else
              want_dur = $urandom_range(0, 2 * int'(cf_long_press) + 2);
            if (want_dur > gen_t - lk_press_start) gen_t = lk_press_start + want_dur;
          end else begin
            case ($urandom_range(0, 19))
              0: gen_t = lk_last_touch + TS_W'(lk_awaiting ? cf_val_limit : cf_gap_limit)
                         + $urandom_range(0, 1);
              1: gen_t += $urandom_range(0, 70000);
              default: gen_t += $urandom_range(0, 400);
            endcase
          end
          e_lvl = pad_level(cf_entry_base, e_touch);
          v_lvl = pad_level(cf_validate_base, v_touch);
        end
        send_sample(e_lvl, v_lvl, gen_t, 1'b0, RES_QUIET);
      end
    end

    in_tvalid <= 1'b0;
    while (pending_lock_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (err_count == 0)
      $display("** touch_duration_pattern_lock_unit: PASSED **");
    else
      $display("** touch_duration_pattern_lock_unit: FAILED **");
    $finish;
  end

endmodule
